>>> design/fsatt_pkg.sv
// shared types, widths and constants of the feedback servo angle and turn tracker
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package fsatt_pkg;

    // field widths
    localparam int TICKS_W    = 24;
    localparam int ANGLE_W    = 12;
    localparam int TURN_W     = 16;
    localparam int CAP_W      = 16;
    localparam int DUTY_W     = 14;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // divider shape: 16 quotient bits, one per step
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_Q_W   = 16;

    // datapath widths of the back end
    localparam int PROD1_W  = 38;   // ticks * 10000
    localparam int PROD2_W  = 27;   // |duty offset| * 3600, offset clamped to 15 bits
    localparam int DENOM_W  = 15;
    localparam int DIFF_W   = 18;
    localparam int DMAG_W   = 15;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;

    // register reset values
    localparam logic [DUTY_W-1:0]   DUTY_MIN_RST = 14'd290;
    localparam logic [DUTY_W-1:0]   DUTY_MAX_RST = 14'd9710;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd1100;

    // arithmetic constants
    localparam logic [13:0]         CENTI_FULL        = 14'd10000;
    localparam logic [15:0]         CENTI_ONE_PERCENT = 16'd100;
    localparam logic [ANGLE_W-1:0]  TENTHS_FULL       = 12'd3600;
    localparam logic [ANGLE_W-1:0]  ANGLE_TOP         = 12'd3590;
    localparam logic [ANGLE_W-1:0]  ANGLE_MAX         = 12'd3599;
    localparam logic [ANGLE_W-1:0]  QUAD_LOW          = 12'd900;
    localparam logic [ANGLE_W-1:0]  QUAD_HIGH         = 12'd2700;
    localparam logic [DMAG_W-1:0]   DMAG_MAX          = 15'h7FFF;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty_min;
        logic [DUTY_W-1:0]   duty_max;
        logic [PERIOD_W-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DUTY,
        B_DUTY_WAIT,
        B_SCALE,
        B_ANGLE_DIV,
        B_ANGLE_WAIT,
        B_FINISH
    } back_state_t;

endpackage

>>> design/fsatt_front.sv
// front end: edge pairing, overflow counting and pulse length measurement
// depends on fsatt_pkg
`timescale 1ns / 1ps

module fsatt_front
    import fsatt_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int WRAP_BITS  = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               edge_seen,
    input  logic [CAP_W-1:0]   capture_value,
    input  logic               overflow_seen,
    output logic               q_push,
    output logic [TICKS_W-1:0] q_data
);

    localparam int SUM_RAW = TIMER_BITS + WRAP_BITS + 2;
    localparam int SUM_W   = (SUM_RAW > TICKS_W + 2) ? SUM_RAW : TICKS_W + 2;
    localparam logic [CAP_W-1:0] CAP_MASK = (TIMER_BITS >= CAP_W) ? {CAP_W{1'b1}}
                                          : CAP_W'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [SUM_W-1:0] TICKS_TOP = {{(SUM_W - TICKS_W){1'b0}}, {TICKS_W{1'b1}}};

    logic [CAP_W-1:0]     rise_stamp_reg;
    logic                 pulse_open_reg;
    logic [WRAP_BITS-1:0] wrap_count_reg;

    logic [CAP_W-1:0]     cap_m;
    logic [SUM_W-1:0]     span_sum;
    logic                 span_neg;
    logic                 span_big;

    assign cap_m    = capture_value & CAP_MASK;
    // signed span plus overflow weight, msb is the sign
    assign span_sum = SUM_W'(cap_m) - SUM_W'(rise_stamp_reg)
                    + (SUM_W'(wrap_count_reg) << TIMER_BITS);
    assign span_neg = span_sum[SUM_W-1];
    assign span_big = !span_neg && (span_sum > TICKS_TOP);

    assign q_push = accept && edge_seen && pulse_open_reg;
    assign q_data = span_neg ? '0 : (span_big ? {TICKS_W{1'b1}} : span_sum[TICKS_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_stamp_reg <= '0;
            pulse_open_reg <= 1'b0;
            wrap_count_reg <= '0;
        end
        else if (accept)
        begin
            if (edge_seen && !pulse_open_reg)
            begin
                // opening edge; an overflow in the same event already counts
                rise_stamp_reg <= cap_m;
                pulse_open_reg <= 1'b1;
                wrap_count_reg <= WRAP_BITS'(overflow_seen);
            end
            else if (edge_seen)
            begin
                // closing edge; a same-event overflow is dropped
                pulse_open_reg <= 1'b0;
            end
            else if (overflow_seen && pulse_open_reg && (wrap_count_reg != {WRAP_BITS{1'b1}}))
            begin
                wrap_count_reg <= wrap_count_reg + 1'b1;
            end
        end
    end

endmodule

>>> design/fsatt_queue.sv
// short queue of measured pulse lengths between front and back
// depends on fsatt_pkg
`timescale 1ns / 1ps

module fsatt_queue
    import fsatt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [TICKS_W-1:0] push_data,
    output logic               full,
    input  logic               pop,
    output logic [TICKS_W-1:0] pop_data,
    output logic               empty
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [TICKS_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg;
    logic [IDX_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/fsatt_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on fsatt_pkg; caller guarantees the quotient fits DIV_Q_W bits
`timescale 1ns / 1ps

module fsatt_div
    import fsatt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   lo_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, lo_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    assign rsp.done     = busy_reg && (cnt_reg == '0);
    assign rsp.quotient = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_Q_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[DIV_NUM_W-1:DIV_Q_W];
            lo_reg  <= req.dividend[DIV_Q_W-1:0];
            den_reg <= req.divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            lo_reg  <= {lo_reg[DIV_Q_W-2:0], ge};
        end
    end

endmodule

>>> design/fsatt_back.sv
// back end: duty, angle and turn tracking, result register
// depends on fsatt_pkg; drives the shared divider fsatt_div
`timescale 1ns / 1ps

module fsatt_back
    import fsatt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_empty,
    input  logic [TICKS_W-1:0]       q_data,
    output logic                     q_pop,
    output div_req_t                 div_req,
    input  div_rsp_t                 div_rsp,
    input  logic                     res_pop,
    output logic                     res_empty,
    output logic [ANGLE_W-1:0]       angle_tenths,
    output logic signed [TURN_W-1:0] turn_total,
    output logic [TICKS_W-1:0]       pulse_ticks
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [TICKS_W-1:0]       ticks_work_reg;
    logic [PROD1_W-1:0]       prod1_reg;
    logic [DIV_Q_W-1:0]       duty_reg;
    logic [PROD2_W-1:0]       prod2_reg;
    logic                     neg_reg;
    logic [DENOM_W-1:0]       denom_reg;
    logic [DIV_Q_W-1:0]       qmag_reg;
    logic [TICKS_W-1:0]       res_ticks_reg;
    logic                     res_valid_reg;
    logic [ANGLE_W-1:0]       last_angle_reg;
    logic signed [TURN_W-1:0] turn_store_reg;

    logic [PERIOD_W-1:0]      period_eff;
    logic                     fits1;
    logic                     fits2;
    logic [DIFF_W-1:0]        d_diff;
    logic [DIFF_W-1:0]        d_flip;
    logic [DIFF_W-2:0]        d_abs;
    logic [DMAG_W-1:0]        d_mag;
    logic [15:0]              denom_raw;
    logic [DENOM_W-1:0]       denom_eff;
    logic [ANGLE_W-1:0]       angle_new;
    logic                     turn_inc;
    logic                     turn_dec;
    logic                     pop_ok;
    logic                     res_load;

    assign pop_ok    = res_pop && res_valid_reg;
    assign res_empty = !res_valid_reg;

    // zero period acts as one
    assign period_eff = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
    assign fits1      = (prod1_reg[PROD1_W-1:DIV_Q_W] < (PROD1_W - DIV_Q_W)'(period_eff));

    // duty offset, magnitude clamped: beyond the divisor the angle saturates anyway
    assign d_diff = {{(DIFF_W - DIV_Q_W){1'b0}}, duty_reg}
                  - {{(DIFF_W - DUTY_W){1'b0}}, cfg.duty_min};
    assign d_flip = -d_diff;
    assign d_abs  = d_diff[DIFF_W-1] ? d_flip[DIFF_W-2:0] : d_diff[DIFF_W-2:0];
    assign d_mag  = (d_abs > (DIFF_W - 1)'(DMAG_MAX)) ? DMAG_MAX : d_abs[DMAG_W-1:0];

    // non-positive divisor acts as one
    assign denom_raw = {2'b00, cfg.duty_max} - {2'b00, cfg.duty_min} + CENTI_ONE_PERCENT;
    assign denom_eff = (denom_raw[15] || (denom_raw == '0)) ? DENOM_W'(1)
                     : denom_raw[DENOM_W-1:0];
    assign fits2     = (DENOM_W'(prod2_reg[PROD2_W-1:DIV_Q_W]) < denom_reg);

    always_comb
    begin
        if (neg_reg)
        begin
            angle_new = (qmag_reg >= DIV_Q_W'(ANGLE_MAX - ANGLE_TOP)) ? ANGLE_MAX
                      : ANGLE_TOP + qmag_reg[ANGLE_W-1:0];
        end
        else
        begin
            angle_new = (qmag_reg >= DIV_Q_W'(ANGLE_TOP)) ? '0
                      : ANGLE_TOP - qmag_reg[ANGLE_W-1:0];
        end
    end

    assign turn_inc = (angle_new < QUAD_LOW) && (last_angle_reg > QUAD_HIGH);
    assign turn_dec = (last_angle_reg < QUAD_LOW) && (angle_new > QUAD_HIGH);

    always_comb
    begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        res_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod1_reg[DIV_NUM_W-1:0];
        div_req.divisor  = period_eff;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_DUTY;
                end
            end
            B_DUTY:
            begin
                if (fits1)
                begin
                    div_req.start = 1'b1;
                    state_next    = B_DUTY_WAIT;
                end
                else
                begin
                    state_next = B_SCALE;
                end
            end
            B_DUTY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = B_SCALE;
                end
            end
            B_SCALE:
            begin
                state_next = B_ANGLE_DIV;
            end
            B_ANGLE_DIV:
            begin
                div_req.dividend = DIV_NUM_W'(prod2_reg);
                div_req.divisor  = DIV_DEN_W'(denom_reg);
                if (fits2)
                begin
                    div_req.start = 1'b1;
                    state_next    = B_ANGLE_WAIT;
                end
                else
                begin
                    state_next = B_FINISH;
                end
            end
            B_ANGLE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = B_FINISH;
                end
            end
            B_FINISH:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            res_valid_reg  <= 1'b0;
            last_angle_reg <= '0;
            turn_store_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg  <= 1'b1;
                last_angle_reg <= angle_new;
                if (turn_inc && (turn_store_reg != 16'sh7FFF))
                begin
                    turn_store_reg <= turn_store_reg + 16'sd1;
                end
                else if (turn_dec && (turn_store_reg != 16'sh8000))
                begin
                    turn_store_reg <= turn_store_reg - 16'sd1;
                end
            end
            else if (pop_ok)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    ticks_work_reg <= q_data;
                    prod1_reg      <= PROD1_W'(q_data) * PROD1_W'(CENTI_FULL);
                end
            end
            B_DUTY:
            begin
                if (!fits1)
                begin
                    duty_reg <= '1;
                end
            end
            B_DUTY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    duty_reg <= div_rsp.quotient;
                end
            end
            B_SCALE:
            begin
                prod2_reg <= PROD2_W'(d_mag) * PROD2_W'(TENTHS_FULL);
                neg_reg   <= d_diff[DIFF_W-1];
                denom_reg <= denom_eff;
            end
            B_ANGLE_DIV:
            begin
                if (!fits2)
                begin
                    qmag_reg <= '1;
                end
            end
            B_ANGLE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    qmag_reg <= div_rsp.quotient;
                end
            end
            B_FINISH:
            begin
                if (res_load)
                begin
                    res_ticks_reg <= ticks_work_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign angle_tenths = last_angle_reg;
    assign turn_total   = turn_store_reg;
    assign pulse_ticks  = res_ticks_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == B_DUTY_WAIT || state_reg == B_ANGLE_WAIT))
        else $error("divider finished outside a wait state");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (last_angle_reg <= ANGLE_MAX))
        else $error("angle out of range");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !res_load |=> ($stable(turn_store_reg) && $stable(last_angle_reg)))
        else $error("tracking state changed without a result");

    a_finish_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FINISH && res_valid_reg && !res_pop) |=> (state_reg == B_FINISH))
        else $error("result overwritten before transfer");
`endif

endmodule

>>> design/feedback_servo_angle_turn_tracker.sv
// top level of the feedback servo angle and turn tracker
// depends on fsatt_pkg, fsatt_front, fsatt_queue, fsatt_div, fsatt_back
`timescale 1ns / 1ps

// Decodes the feedback pwm line of a continuous rotation servo from timer events.
// Each event pushed in may carry an edge capture, a timer overflow or both (the
// edge is handled first). Edges alternate opening and closing a pulse; overflows
// are counted while a pulse is open. Every closing edge yields one result with the
// angle in tenths of a degree (0..3599), the saturating signed turn count and the
// measured high time in ticks. A closing edge is measured combinationally in the
// front end and queued (two entries); the back end then uses one shared 16-step
// restoring divider twice (duty, then angle), skipping the division when a
// quotient is known to saturate. Input stalls (full) only once the queue holds two
// unprocessed pulses; results wait in an output register while the back end goes
// on up to its next result. Registers are written through the cfg channel, which
// is always ready, and should only change while the block is idle.

module feedback_servo_angle_turn_tracker
    import fsatt_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int WRAP_BITS  = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // event input
    input  logic                     push,
    output logic                     full,
    input  logic                     edge_seen,
    input  logic [CAP_W-1:0]         capture_value,
    input  logic                     overflow_seen,
    // result output
    output logic                     empty,
    input  logic                     pop,
    output logic [ANGLE_W-1:0]       angle_tenths,
    output logic signed [TURN_W-1:0] turn_total,
    output logic [TICKS_W-1:0]       pulse_ticks,
    // register writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    cfg_t               cfg_reg;
    logic               in_xfer;
    logic               q_push;
    logic [TICKS_W-1:0] q_push_data;
    logic               q_full;
    logic               q_pop;
    logic [TICKS_W-1:0] q_pop_data;
    logic               q_empty;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // input transfer whenever the queue has room, even with a result waiting
    assign full      = q_full;
    assign in_xfer   = push && !q_full;
    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_min <= DUTY_MIN_RST;
            cfg_reg.duty_max <= DUTY_MAX_RST;
            cfg_reg.period   <= PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DUTY_MIN: cfg_reg.duty_min <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_MAX: cfg_reg.duty_max <= cfg_data[DUTY_W-1:0];
                CFG_PERIOD:   cfg_reg.period   <= cfg_data[PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: edge pairing and pulse length, one event per cycle while the queue is not full
    fsatt_front #(
        .TIMER_BITS (TIMER_BITS),
        .WRAP_BITS  (WRAP_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_xfer),
        .edge_seen     (edge_seen),
        .capture_value (capture_value),
        .overflow_seen (overflow_seen),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // decouples measurement from the slow duty and angle math
    fsatt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // one divider shared by the duty and angle steps
    fsatt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back: duty, angle, turn tracking and the result register
    fsatt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .res_pop      (pop),
        .res_empty    (empty),
        .angle_tenths (angle_tenths),
        .turn_total   (turn_total),
        .pulse_ticks  (pulse_ticks)
    );

endmodule
